// ===== rtl/ffba_pkg.sv =====
// ffba_pkg: shared types and constants for the first-fit block allocator.
// Used by ffba_scan and first_fit_block_allocator_core; no dependencies.
package ffba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 24;
    localparam int HDR_W      = 8;
    localparam int GROW_W     = SIZE_W + 1;
    localparam int ENTRY_W    = ADDR_W + SIZE_W;

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 120;
    localparam int CFG_IDX_W  = 2;

    localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 8'd16;
    localparam logic [ADDR_W-1:0] HEAP_END_RST     = 32'd1048576;
    localparam logic [ADDR_W-1:0] HEAP_START_RST   = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_START   = 2'd0,
        CFG_HEAP_END     = 2'd1,
        CFG_HEADER_BYTES = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_REALLOC = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOSPACE  = 2'd1,
        STAT_BADARG   = 2'd2,
        STAT_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    // table update from the finish step
    typedef struct packed {
        logic              wr_en;
        logic              set_en;
        logic [IDX_W-1:0]  set_idx;
        logic [ADDR_W-1:0] wr_start;
        logic [SIZE_W-1:0] wr_cap;
        logic              clr_en;
        logic [IDX_W-1:0]  clr_idx;
    } t_tbl_cmd;

    // outcome of one pass over the table
    typedef struct packed {
        logic              done;
        logic              fit_found;
        logic [IDX_W-1:0]  fit_idx;
        logic [ADDR_W-1:0] fit_data;
        logic              mat_found;
        logic [IDX_W-1:0]  mat_idx;
        logic [SIZE_W-1:0] mat_cap;
    } t_scan_res;

endpackage

// ===== rtl/first_fit_block_allocator_core.sv =====
// Each word goes through a linear scan of the block table (one table RAM read per entry,
// then the read-data register), scan done, the finish step and the result register.
// Throughput: one word at a time, set by the single-port scan of the block table.
// The result register lets the next word be taken while a result waits.
// Reset (synchronous, active low): empty table, all used bits clear, heap break at
// the heap_start reset value, growth total zero, configuration registers at reset values.
module first_fit_block_allocator_core import ffba_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    // request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // request_size[23:0], data_address[55:24]
    input  logic [1:0]           i_s_tuser,  // action[1:0]
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // result_address[31:0], copy_source[63:32],
                                             // copy_length[87:64], heap_grown_total[119:88]
    output logic [1:0]           o_m_tuser   // status[1:0]
);

    t_state              r_state, n_state;
    t_action             r_action;
    logic [SIZE_W-1:0]   r_size;
    logic [ADDR_W-1:0]   r_addr;
    logic [GROW_W-1:0]   r_grow;

    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_break;
    logic [ADDR_W-1:0]   r_grown;
    logic [ADDR_W-1:0]   r_heap_end;
    logic [HDR_W-1:0]    r_hdr;

    logic                r_out_vld;
    logic [ADDR_W-1:0]   r_res_addr;
    t_status             r_status;
    logic [ADDR_W-1:0]   r_csrc;
    logic [SIZE_W-1:0]   r_clen;
    logic [ADDR_W-1:0]   r_out_total;

    logic                s_accept;
    logic                cfg_accept;
    logic                fin_go;
    t_scan_res           scan_res;
    t_tbl_cmd            tbl_cmd;

    logic [ADDR_W:0]     new_break;
    logic [ADDR_W:0]     grown_sum;
    logic [ADDR_W-1:0]   grown_sat;
    logic                grow_ok;
    logic                a_ok;
    logic [ADDR_W-1:0]   a_addr;
    t_status             a_status;
    logic                use_alloc;
    logic                use_free;
    logic                is_move;

    t_status             f_status;
    logic [ADDR_W-1:0]   f_addr;
    logic [ADDR_W-1:0]   f_csrc;
    logic [SIZE_W-1:0]   f_clen;
    logic                f_set;
    logic                f_app;
    logic                f_clr;
    logic [ADDR_W-1:0]   f_total;

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign fin_go      = (r_state == S_FIN) && (!r_out_vld || i_m_tready);

    // heap_start only matters at reset, where the break takes its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_end <= HEAP_END_RST;
            r_hdr      <= HEADER_BYTES_RST;
        end else if (cfg_accept) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HEAP_END:     r_heap_end <= i_cfg_data;
                CFG_HEADER_BYTES: r_hdr      <= i_cfg_data[HDR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_action <= t_action'(i_s_tuser);
            r_size   <= i_s_tdata[SIZE_W-1:0];
            r_addr   <= i_s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
            r_grow   <= GROW_W'(i_s_tdata[SIZE_W-1:0]) + GROW_W'(r_hdr);
        end
    end

    ffba_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept),
        .i_count (r_count),
        .i_size  (r_size),
        .i_addr  (r_addr),
        .i_hdr   (r_hdr),
        .i_cmd   (tbl_cmd),
        .o_res   (scan_res)
    );

    // growth path
    assign new_break = {1'b0, r_break} + (ADDR_W+1)'(r_grow);
    assign grown_sum = {1'b0, r_grown} + (ADDR_W+1)'(r_grow);
    assign grown_sat = grown_sum[ADDR_W] ? '1 : grown_sum[ADDR_W-1:0];
    assign grow_ok   = (r_count < CNT_W'(MAX_BLOCKS)) && !new_break[ADDR_W]
                       && (new_break[ADDR_W-1:0] <= r_heap_end);

    assign a_ok      = (r_size != '0) && (scan_res.fit_found || grow_ok);
    assign a_addr    = !a_ok ? '0 :
                       scan_res.fit_found ? scan_res.fit_data : r_break + ADDR_W'(r_hdr);
    assign a_status  = (r_size == '0) ? STAT_BADARG : (a_ok ? STAT_OK : STAT_NOSPACE);

    always_comb begin
        use_alloc = 1'b0;
        use_free  = 1'b0;
        is_move   = 1'b0;
        f_status  = STAT_BADARG;
        f_addr    = '0;
        f_csrc    = '0;
        f_clen    = '0;
        f_set     = 1'b0;
        f_app     = 1'b0;
        f_clr     = 1'b0;
        case (r_action)
            ACT_ALLOC: use_alloc = 1'b1;
            ACT_FREE:  use_free  = 1'b1;
            ACT_REALLOC: begin
                if (r_addr == '0) begin
                    use_alloc = 1'b1;
                end else if (r_size == '0) begin
                    use_free = 1'b1;
                end else if (!scan_res.mat_found) begin
                    f_status = STAT_NOTFOUND;
                end else if (scan_res.mat_cap >= r_size) begin
                    f_status = STAT_OK;
                    f_addr   = r_addr;
                end else begin
                    use_alloc = 1'b1;
                    is_move   = 1'b1;
                end
            end
            default: ;
        endcase

        if (use_alloc) begin
            f_status = a_status;
            f_addr   = a_addr;
            f_set    = a_ok;
            f_app    = a_ok && !scan_res.fit_found;
            // moving: old capacity is below the request, so it is the copy length
            if (is_move && a_ok) begin
                f_csrc = r_addr;
                f_clen = scan_res.mat_cap;
                f_clr  = 1'b1;
            end
        end
        if (use_free) begin
            if (r_addr == '0) begin
                f_status = STAT_BADARG;
            end else if (!scan_res.mat_found) begin
                f_status = STAT_NOTFOUND;
            end else begin
                f_status = STAT_OK;
                f_clr    = 1'b1;
            end
        end
    end

    assign f_total = f_app ? grown_sat : r_grown;

    always_comb begin
        tbl_cmd.wr_en    = fin_go && f_app;
        tbl_cmd.set_en   = fin_go && f_set;
        tbl_cmd.set_idx  = scan_res.fit_found ? scan_res.fit_idx : r_count[IDX_W-1:0];
        tbl_cmd.wr_start = r_break;
        tbl_cmd.wr_cap   = r_size;
        tbl_cmd.clr_en   = fin_go && f_clr;
        tbl_cmd.clr_idx  = scan_res.mat_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_break <= HEAP_START_RST;
            r_grown <= '0;
        end else if (fin_go && f_app) begin
            r_count <= r_count + 1'b1;
            r_break <= new_break[ADDR_W-1:0];
            r_grown <= grown_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_accept) n_state = S_SCAN;
            S_SCAN: if (scan_res.done) n_state = S_FIN;
            S_FIN:  if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_go) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_res_addr  <= f_addr;
            r_status    <= f_status;
            r_csrc      <= f_csrc;
            r_clen      <= f_clen;
            r_out_total <= f_total;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_total, r_clen, r_csrc, r_res_addr};
    assign o_m_tuser  = r_status;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_res.done |-> (r_state == S_SCAN))
        else $error("scan finished outside scan state");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && f_app) |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not bump block count");

    a_break_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_break >= $past(r_break)))
        else $error("heap break moved down");
`endif

endmodule

// ===== rtl/ffba_scan.sv =====
// ffba_scan: block table (start/capacity RAM plus used bits) and the linear scan
// that finds the first free fit and the first used block matching an address.
// Depends on ffba_pkg.
module ffba_scan import ffba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [HDR_W-1:0]  i_hdr,
    input  t_tbl_cmd          i_cmd,
    output t_scan_res         o_res
);

    logic [ENTRY_W-1:0]    mem [MAX_BLOCKS];
    logic [ENTRY_W-1:0]    r_rd_data;
    logic [MAX_BLOCKS-1:0] r_used;

    logic                  r_busy;
    logic                  r_chk_vld;
    logic [CNT_W-1:0]      r_rd_idx;
    logic [IDX_W-1:0]      r_chk_idx;

    logic                  r_fit_found;
    logic [IDX_W-1:0]      r_fit_idx;
    logic [ADDR_W-1:0]     r_fit_data;
    logic                  r_mat_found;
    logic [IDX_W-1:0]      r_mat_idx;
    logic [SIZE_W-1:0]     r_mat_cap;

    logic                  issue;
    logic                  done;
    logic [ADDR_W-1:0]     chk_start;
    logic [ADDR_W-1:0]     chk_data;
    logic [SIZE_W-1:0]     chk_cap;
    logic                  chk_used;
    logic                  chk_fit;
    logic                  chk_mat;

    assign issue     = r_busy && (r_rd_idx < i_count);
    assign done      = r_busy && !issue && !r_chk_vld;

    assign chk_start = r_rd_data[ENTRY_W-1:SIZE_W];
    assign chk_cap   = r_rd_data[SIZE_W-1:0];
    assign chk_data  = chk_start + ADDR_W'(i_hdr);
    assign chk_used  = r_used[r_chk_idx];
    assign chk_fit   = r_chk_vld && !chk_used && (chk_cap >= i_size);
    assign chk_mat   = r_chk_vld && chk_used && (chk_data == i_addr);

    // writes only happen in the finish step, never while a scan reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.set_idx] <= {i_cmd.wr_start, i_cmd.wr_cap};
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (i_cmd.clr_en) begin
                r_used[i_cmd.clr_idx] <= 1'b0;
            end
            if (i_cmd.set_en) begin
                r_used[i_cmd.set_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_rd_idx    <= '0;
            r_chk_idx   <= '0;
            r_fit_found <= 1'b0;
            r_mat_found <= 1'b0;
        end else if (i_start) begin
            r_busy      <= 1'b1;
            r_chk_vld   <= 1'b0;
            r_rd_idx    <= '0;
            r_fit_found <= 1'b0;
            r_mat_found <= 1'b0;
        end else if (r_busy) begin
            if (done) begin
                r_busy <= 1'b0;
            end
            r_chk_vld <= issue;
            r_chk_idx <= r_rd_idx[IDX_W-1:0];
            if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (chk_fit && !r_fit_found) begin
                r_fit_found <= 1'b1;
            end
            if (chk_mat && !r_mat_found) begin
                r_mat_found <= 1'b1;
            end
        end
    end

    // first hit wins; later hits are ignored
    always_ff @(posedge i_clk) begin
        if (r_busy && chk_fit && !r_fit_found) begin
            r_fit_idx  <= r_chk_idx;
            r_fit_data <= chk_data;
        end
        if (r_busy && chk_mat && !r_mat_found) begin
            r_mat_idx <= r_chk_idx;
            r_mat_cap <= chk_cap;
        end
    end

    always_comb begin
        o_res.done      = done;
        o_res.fit_found = r_fit_found;
        o_res.fit_idx   = r_fit_idx;
        o_res.fit_data  = r_fit_data;
        o_res.mat_found = r_mat_found;
        o_res.mat_idx   = r_mat_idx;
        o_res.mat_cap   = r_mat_cap;
    end

endmodule
